/* rtl/core/kpsc_pkg.sv */
package kpsc_pkg;

  // Port value seen with the row-read pattern driven and no key down
  localparam logic [7:0] ROW_PATTERN = 8'h2B;
  localparam logic [7:0] NO_KEY      = 8'hFF;
  localparam logic [7:0] STAR_CHAR   = 8'h2A;

  // Row codes seen on the port with the row-read pattern driven
  localparam logic [7:0] ROW0_CODE = 8'h0B;
  localparam logic [7:0] ROW1_CODE = 8'h2A;
  localparam logic [7:0] ROW2_CODE = 8'h29;
  localparam logic [7:0] ROW3_CODE = 8'h23;

  // Column codes seen on the port with the column-read pattern driven
  localparam logic [7:0] COL0_CODE = 8'h44;
  localparam logic [7:0] COL1_CODE = 8'h14;
  localparam logic [7:0] COL2_CODE = 8'h50;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd3600;
  localparam int          CODE_LEN_DEF   = 4;

  typedef enum logic [1:0] {
    PH_RELEASE  = 2'd0,
    PH_PRESS    = 2'd1,
    PH_DEBOUNCE = 2'd2
  } scan_phase_t;

  // Key legend by index col*4+row
  localparam logic [7:0] KEY_TABLE [12] = '{
    8'h31, 8'h34, 8'h37, 8'h2A,
    8'h32, 8'h35, 8'h38, 8'h30,
    8'h33, 8'h36, 8'h39, 8'h23
  };

  // Decode row and column port values into an ASCII key, NO_KEY if unknown
  function automatic logic [7:0] decode_key(input logic [7:0] row, input logic [7:0] col);
    logic [1:0] r;
    logic [1:0] c;
    logic       r_ok;
    logic       c_ok;
    logic [3:0] idx;
    r_ok = 1'b1;
    c_ok = 1'b1;
    case (row)
      ROW0_CODE: r = 2'd0;
      ROW1_CODE: r = 2'd1;
      ROW2_CODE: r = 2'd2;
      ROW3_CODE: r = 2'd3;
      default: begin
        r    = 2'd0;
        r_ok = 1'b0;
      end
    endcase
    case (col)
      COL0_CODE: c = 2'd0;
      COL1_CODE: c = 2'd1;
      COL2_CODE: c = 2'd2;
      default: begin
        c    = 2'd0;
        c_ok = 1'b0;
      end
    endcase
    idx = {c, r};
    if (r_ok && c_ok) begin
      return KEY_TABLE[idx];
    end
    return NO_KEY;
  endfunction

endpackage

/* rtl/core/keypad_scan_code_entry_top.sv */
// Keypad scanner with code entry.
// Input channel (in_valid / in_stall) carries one scan tick per item: row_pins
// sampled with the row-read pattern driven and col_pins with the column-read
// pattern driven. The block waits for release, waits for a press, counts
// debounce_ticks further ticks, then decodes the key and writes it into the
// code buffer. Only the decode tick yields a result item on the output
// channel (out_valid / out_stall); all other ticks are absorbed silently.
// Throughput: one tick per cycle while the input is not stalled. A taken
// tick is decoded from the input register and lands in the result register
// when it is processed, which sets out_valid for a decode tick.
// The input stalls only while a result sits in the output register with
// out_stall high and a tick is already held in the input register.
// cfg_write loads debounce_ticks from cfg_data; write it only
// while the block is idle.
// Synchronous reset: phase back to wait for release, counters and the code
// buffer cleared, debounce_ticks back to 3600, both registers emptied.
module keypad_scan_code_entry_top
  import kpsc_pkg::*;
#(
  parameter int CODE_LEN = CODE_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  row_pins,
  input  logic [7:0]  col_pins,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  key_char,
  output logic        key_ok,
  output logic [1:0]  slot,
  output logic        restarted,
  output logic        code_done,
  output logic [31:0] code_word,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(CODE_LEN - 1);

  logic [15:0]      debounce_ticks;
  logic             s1_valid;
  logic [7:0]       s1_row;
  logic [7:0]       s1_col;
  logic             advance;

  scan_phase_t      phase;
  scan_phase_t      phase_next;
  logic [15:0]      debounce_count;
  logic [15:0]      debounce_count_next;
  logic [IDX_W-1:0] entry_index;
  logic [IDX_W-1:0] entry_index_next;
  logic [7:0]       entered_chars [CODE_LEN];

  logic             produce;
  logic             down;
  logic [7:0]       ch;
  logic [IDX_W-1:0] pos;
  logic             star;
  logic             done;
  logic [31:0]      word;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
    end else if (cfg_write) begin
      debounce_ticks <= cfg_data;
    end
  end

  // Process the held tick unless a result is blocked at the output
  assign advance  = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_row <= row_pins;
      s1_col <= col_pins;
    end
  end

  // Decode path
  assign down = (s1_row != ROW_PATTERN);
  assign ch   = decode_key(s1_row, s1_col);
  assign pos  = (entry_index <= LAST_POS) ? entry_index : '0;
  assign star = (ch == STAR_CHAR);
  assign done = !star && (pos == LAST_POS);

  // Assemble the code word as it stands after this write
  for (genvar k = 0; k < 4; k++) begin : g_word
    if (k < CODE_LEN) begin : g_used
      assign word[8*k +: 8] = (pos == IDX_W'(k)) ? ch : entered_chars[k];
    end else begin : g_unused
      assign word[8*k +: 8] = 8'h00;
    end
  end

  // Next phase, debounce count and entry position
  always_comb begin
    phase_next          = phase;
    debounce_count_next = debounce_count;
    entry_index_next    = entry_index;
    produce             = 1'b0;
    case (phase)
      PH_RELEASE: begin
        if (!down) begin
          phase_next = PH_PRESS;
        end
      end
      PH_PRESS: begin
        if (down) begin
          phase_next          = PH_DEBOUNCE;
          debounce_count_next = 16'd0;
        end
      end
      PH_DEBOUNCE: begin
        if (debounce_count < debounce_ticks) begin
          debounce_count_next = debounce_count + 16'd1;
        end else begin
          produce             = 1'b1;
          phase_next          = PH_RELEASE;
          debounce_count_next = 16'd0;
          if (star || done) begin
            entry_index_next = '0;
          end else begin
            entry_index_next = pos + IDX_W'(1);
          end
        end
      end
      default: begin
        phase_next = PH_RELEASE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_RELEASE;
      debounce_count <= 16'd0;
      entry_index    <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      debounce_count <= debounce_count_next;
      entry_index    <= entry_index_next;
    end
  end

  // Code buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CODE_LEN; i++) begin
        entered_chars[i] <= 8'h00;
      end
    end else if (advance && produce) begin
      entered_chars[pos] <= ch;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= produce;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      key_char  <= ch;
      key_ok    <= (ch != NO_KEY);
      slot      <= 2'(pos);
      restarted <= star;
      code_done <= done;
      code_word <= word;
    end
  end

endmodule

/* rtl/core/kpsc_checker.sv */
module kpsc_checker
  import kpsc_pkg::*;
#(
  parameter int CODE_LEN = CODE_LEN_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  key_char,
  input logic        key_ok,
  input logic [1:0]  slot,
  input logic        restarted,
  input logic        code_done,
  input logic [31:0] code_word
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(key_char) && $stable(code_word))
    else $error("stalled result changed");

  // Flag a good key exactly when the character is not the no-key code
  a_key_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (key_ok == (key_char != NO_KEY)))
    else $error("key_ok disagrees with key_char");

  // Restart only on star, and never together with a finished code
  a_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid && restarted |-> key_char == STAR_CHAR && !code_done)
    else $error("restart without star key");

  // Finish the code only on the last position
  a_done_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && code_done |-> slot == 2'(CODE_LEN - 1))
    else $error("code done on wrong slot");

  // Show the written character in its slot of the code word (checked only when CODE_LEN is at most four)
  a_word_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CODE_LEN > 4) || (8'(code_word >> {slot, 3'b000}) == key_char))
    else $error("code word slot does not hold key_char");

endmodule

bind keypad_scan_code_entry_top kpsc_checker #(
  .CODE_LEN(CODE_LEN)
) u_kpsc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .key_char  (key_char),
  .key_ok    (key_ok),
  .slot      (slot),
  .restarted (restarted),
  .code_done (code_done),
  .code_word (code_word)
);
